/* hw/rtl/pus_pkg.sv */
`default_nettype none
package pus_pkg;

   localparam int PEER_ID_W   = 6;
   localparam int RATE_IN_W   = 32;
   localparam int COUNT_W     = 7;
   localparam int CMD_W       = 3;
   localparam int DEF_PEERS   = 64;
   localparam int DEF_RATE_W  = 32;
   localparam logic [COUNT_W-1:0] MAX_UNCHOKED_RST = 7'd4;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD        = 3'd0,
      CMD_REMOVE     = 3'd1,
      CMD_SET_RATE   = 3'd2,
      CMD_UNCHOKE    = 3'd3,
      CMD_DECIDE     = 3'd4,
      CMD_OPTIMISTIC = 3'd5
   } command_type;

   typedef enum logic [1:0] {
      ACT_NONE    = 2'd0,
      ACT_CHOKE   = 2'd1,
      ACT_UNCHOKE = 2'd2
   } action_type;

   // which peer index an armed result reports
   typedef enum logic [1:0] {
      TSEL_REQ    = 2'd0,
      TSEL_ZERO   = 2'd1,
      TSEL_BEST   = 2'd2,
      TSEL_CHOSEN = 2'd3
   } tsel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SWEEP_LAST,
      ST_EMIT_LAST,
      ST_D_SCAN,
      ST_D_APPLY,
      ST_D_SWEEP,
      ST_D_EMIT,
      ST_O_FIND,
      ST_O_ROT,
      ST_O_WORST,
      ST_O_EMIT
   } state_type;

   typedef struct packed {
      logic       latch;
      logic       add_apply;
      logic       rem_apply;
      logic       rate_apply;
      logic       unchoke_req;
      logic       unchoke_chosen;
      logic       set_best;
      logic       choke_best;
      logic       taken_clear;
      logic       rank_step;
      logic       scan_start;
      logic       scan_max;
      logic       list_start;
      logic       list_copy;
      logic       list_rot;
      logic       skip_best;
      logic       list_commit;
      logic       arm;
      action_type arm_action;
      tsel_type   arm_tsel;
      logic       arm_status;
      logic       fire;
      logic       fire_last;
   } pus_cmd_type;

   typedef struct packed {
      command_type command;
      logic        peer_valid;
      logic        here;
      logic        on_req;
      logic        on_best;
      logic        empty;
      logic        scan_done;
      logic        scan_found;
      logic        list_done;
      logic        list_found;
      logic        below_max;
      logic        rank_last;
      logic        out_free;
   } pus_stat_type;

endpackage
`default_nettype wire

/* hw/rtl/pus_ctrl.sv */
`default_nettype none
module pus_ctrl
   import pus_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire pus_stat_type stat,
   output pus_cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            state_in = ST_EMIT_LAST;
            cmd.arm  = 1'b1;
            case (stat.command)
               CMD_ADD: begin
                  cmd.arm_tsel   = TSEL_REQ;
                  cmd.arm_status = !stat.peer_valid;
                  cmd.add_apply  = stat.peer_valid && !stat.here;
               end
               CMD_REMOVE: begin
                  cmd.arm_tsel   = TSEL_REQ;
                  cmd.arm_status = !stat.here;
                  if (stat.here) begin
                     cmd.rem_apply = 1'b1;
                     if (stat.on_req) begin
                        cmd.list_start = 1'b1;
                        cmd.list_copy  = 1'b1;
                        state_in       = ST_SWEEP_LAST;
                     end
                  end
               end
               CMD_SET_RATE: begin
                  cmd.arm_tsel   = TSEL_REQ;
                  cmd.arm_status = !stat.here;
                  cmd.rate_apply = stat.here;
               end
               CMD_UNCHOKE: begin
                  cmd.arm_tsel   = TSEL_REQ;
                  cmd.arm_status = !stat.here;
                  if (stat.here) begin
                     cmd.unchoke_req = 1'b1;
                     cmd.arm_action  = ACT_UNCHOKE;
                     if (stat.on_req) begin
                        cmd.list_start = 1'b1;
                        cmd.list_copy  = 1'b1;
                        state_in       = ST_SWEEP_LAST;
                     end
                  end
               end
               CMD_DECIDE: begin
                  cmd.arm_tsel = TSEL_ZERO;
                  if (!stat.empty) begin
                     cmd.arm         = 1'b0;
                     cmd.taken_clear = 1'b1;
                     cmd.scan_start  = 1'b1;
                     cmd.scan_max    = 1'b1;
                     state_in        = ST_D_SCAN;
                  end
               end
               CMD_OPTIMISTIC: begin
                  cmd.arm        = 1'b0;
                  cmd.list_start = 1'b1;
                  state_in       = ST_O_FIND;
               end
               default: begin
                  cmd.arm_tsel = TSEL_ZERO;
               end
            endcase
         end
         ST_SWEEP_LAST: begin
            if (stat.list_done) begin
               cmd.list_commit = 1'b1;
               state_in        = ST_EMIT_LAST;
            end
         end
         ST_EMIT_LAST: begin
            if (stat.out_free) begin
               cmd.fire      = 1'b1;
               cmd.fire_last = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_D_SCAN: begin
            if (stat.scan_done) begin
               state_in = ST_D_APPLY;
            end
         end
         ST_D_APPLY: begin
            cmd.arm      = 1'b1;
            cmd.arm_tsel = TSEL_BEST;
            state_in     = ST_D_EMIT;
            if (stat.below_max) begin
               cmd.set_best   = 1'b1;
               cmd.arm_action = ACT_UNCHOKE;
               if (stat.on_best) begin
                  cmd.list_start = 1'b1;
                  cmd.list_copy  = 1'b1;
                  cmd.skip_best  = 1'b1;
                  state_in       = ST_D_SWEEP;
               end
            end else begin
               cmd.choke_best = 1'b1;
               cmd.arm_action = ACT_CHOKE;
            end
         end
         ST_D_SWEEP: begin
            if (stat.list_done) begin
               cmd.list_commit = 1'b1;
               state_in        = ST_D_EMIT;
            end
         end
         ST_D_EMIT: begin
            if (stat.out_free) begin
               cmd.fire      = 1'b1;
               cmd.fire_last = stat.rank_last;
               cmd.rank_step = 1'b1;
               if (stat.rank_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.scan_start = 1'b1;
                  cmd.scan_max   = 1'b1;
                  state_in       = ST_D_SCAN;
               end
            end
         end
         ST_O_FIND: begin
            if (stat.list_done) begin
               if (stat.list_found) begin
                  cmd.list_start = 1'b1;
                  cmd.list_copy  = 1'b1;
                  cmd.list_rot   = 1'b1;
                  state_in       = ST_O_ROT;
               end else begin
                  cmd.arm      = 1'b1;
                  cmd.arm_tsel = TSEL_ZERO;
                  state_in     = ST_EMIT_LAST;
               end
            end
         end
         ST_O_ROT: begin
            if (stat.list_done) begin
               cmd.list_commit = 1'b1;
               cmd.scan_start  = 1'b1;
               state_in        = ST_O_WORST;
            end
         end
         ST_O_WORST: begin
            if (stat.scan_done) begin
               cmd.arm = 1'b1;
               if (stat.scan_found) begin
                  cmd.choke_best = 1'b1;
                  cmd.arm_action = ACT_CHOKE;
                  cmd.arm_tsel   = TSEL_BEST;
                  state_in       = ST_O_EMIT;
               end else begin
                  cmd.unchoke_chosen = 1'b1;
                  cmd.arm_action     = ACT_UNCHOKE;
                  cmd.arm_tsel       = TSEL_CHOSEN;
                  state_in           = ST_EMIT_LAST;
               end
            end
         end
         ST_O_EMIT: begin
            if (stat.out_free) begin
               cmd.fire           = 1'b1;
               cmd.unchoke_chosen = 1'b1;
               cmd.arm            = 1'b1;
               cmd.arm_action     = ACT_UNCHOKE;
               cmd.arm_tsel       = TSEL_CHOSEN;
               state_in           = ST_EMIT_LAST;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

/* hw/rtl/pus_datapath.sv */
`default_nettype none
module pus_datapath
   import pus_pkg::*;
#(
   parameter int MAX_PEERS = DEF_PEERS,
   parameter int RATE_BITS = DEF_RATE_W
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire pus_cmd_type          cmd,
   output pus_stat_type              stat,
   input  wire logic [CMD_W-1:0]     req_command,
   input  wire logic [PEER_ID_W-1:0] req_peer_id,
   input  wire logic [RATE_IN_W-1:0] req_upload_rate,
   input  wire logic                 req_interested,
   input  wire logic                 csr_write_enable,
   input  wire logic [COUNT_W-1:0]   csr_write_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [1:0]                rsp_action,
   output logic [PEER_ID_W-1:0]      rsp_target_peer,
   output logic                      rsp_status,
   output logic [COUNT_W-1:0]        rsp_peer_count,
   output logic                      rsp_last
);

   localparam int IDX_W = $clog2(MAX_PEERS);
   localparam int CNT_W = $clog2(MAX_PEERS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PEERS - 1);

   // latched request
   logic [CMD_W-1:0]     req_cmd_ff;
   logic [PEER_ID_W-1:0] req_peer_ff;
   logic [RATE_BITS-1:0] req_rate_ff;
   logic                 req_intr_ff;
   logic [IDX_W-1:0]     req_idx;
   logic                 peer_valid;

   logic [COUNT_W-1:0] max_unch_ff;

   // per-peer flags
   logic [MAX_PEERS-1:0] present_ff, present_in;
   logic [MAX_PEERS-1:0] unch_ff, unch_in;
   logic [MAX_PEERS-1:0] intr_ff, intr_in;
   logic [MAX_PEERS-1:0] on_list_ff, on_list_in;
   logic [MAX_PEERS-1:0] taken_ff, taken_in;
   logic [CNT_W-1:0]     peer_cnt_ff, peer_cnt_in;
   logic [CNT_W-1:0]     rank_ff, rank_in;

   // rate memory and scan unit
   logic [RATE_BITS-1:0] rate_mem [MAX_PEERS];
   logic [RATE_BITS-1:0] rate_rd_ff;
   logic                 rate_we;
   logic [RATE_BITS-1:0] rate_wdata;
   logic                 scan_run_ff, scan_pv_ff, scan_max_ff;
   logic [IDX_W-1:0]     scan_addr_ff, scan_pidx_ff;
   logic                 scan_found_ff;
   logic [IDX_W-1:0]     best_idx_ff;
   logic [RATE_BITS-1:0] best_rate_ff;
   logic                 scan_elig, scan_better;

   // wait list, two banks used in turn
   logic [IDX_W-1:0] wl_a [MAX_PEERS];
   logic [IDX_W-1:0] wl_b [MAX_PEERS];
   logic [IDX_W-1:0] wl_a_rd_ff, wl_b_rd_ff;
   logic             bank_ff;
   logic [CNT_W-1:0] wait_cnt_ff, wait_cnt_in;
   logic             lst_run_ff, lst_pv_ff, lst_copy_ff, lst_found_ff;
   logic [CNT_W-1:0] lst_j_ff, lst_pj_ff, lst_base_ff, lst_k_ff, lst_pos_ff;
   logic [IDX_W-1:0] lst_skip_ff, lst_chosen_ff;
   logic [CNT_W:0]   src_sum;
   logic [CNT_W:0]   src_wrap;
   logic [IDX_W-1:0] lst_addr;
   logic [IDX_W-1:0] lst_data;
   logic             copy_wr;
   logic             app_en;
   logic [IDX_W-1:0] app_val;
   logic             wa_we, wb_we;
   logic [IDX_W-1:0] w_addr, w_data;

   // result staging
   action_type       arm_action_ff;
   logic [IDX_W-1:0] arm_target_ff;
   logic             arm_status_ff;
   logic [IDX_W-1:0] arm_target;
   logic             rsp_valid_ff;
   logic [1:0]       rsp_action_ff;
   logic             rsp_status_ff;
   logic [CNT_W-1:0] rsp_count_ff;
   logic             rsp_last_ff;

   assign req_idx    = req_peer_ff[IDX_W-1:0];
   assign peer_valid = {1'b0, req_peer_ff} < (PEER_ID_W + 1)'(MAX_PEERS);

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         req_cmd_ff  <= req_command;
         req_peer_ff <= req_peer_id;
         req_rate_ff <= req_upload_rate[RATE_BITS-1:0];
         req_intr_ff <= req_interested;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_unch_ff <= MAX_UNCHOKED_RST;
      end else if (csr_write_enable) begin
         max_unch_ff <= csr_write_data;
      end
   end

   // flag and counter updates
   assign app_en  = cmd.add_apply || (cmd.choke_best && !on_list_ff[best_idx_ff]);
   assign app_val = cmd.add_apply ? req_idx : best_idx_ff;

   always_comb begin
      present_in  = present_ff;
      unch_in     = unch_ff;
      intr_in     = intr_ff;
      on_list_in  = on_list_ff;
      taken_in    = taken_ff;
      peer_cnt_in = peer_cnt_ff;
      rank_in     = rank_ff;
      wait_cnt_in = wait_cnt_ff;
      if (cmd.add_apply) begin
         present_in[req_idx] = 1'b1;
         unch_in[req_idx]    = 1'b0;
         intr_in[req_idx]    = 1'b0;
         peer_cnt_in         = peer_cnt_ff + CNT_W'(1);
      end
      if (cmd.rem_apply) begin
         present_in[req_idx] = 1'b0;
         unch_in[req_idx]    = 1'b0;
         intr_in[req_idx]    = 1'b0;
         peer_cnt_in         = peer_cnt_ff - CNT_W'(1);
      end
      if (cmd.rate_apply) begin
         intr_in[req_idx] = req_intr_ff;
      end
      if (cmd.unchoke_req) begin
         unch_in[req_idx] = 1'b1;
      end
      if (cmd.set_best) begin
         unch_in[best_idx_ff] = 1'b1;
      end
      if (cmd.choke_best) begin
         unch_in[best_idx_ff] = 1'b0;
      end
      if (cmd.unchoke_chosen) begin
         unch_in[lst_chosen_ff] = 1'b1;
      end
      if (cmd.taken_clear) begin
         taken_in = '0;
         rank_in  = '0;
      end
      if (cmd.rank_step) begin
         taken_in[best_idx_ff] = 1'b1;
         rank_in               = rank_ff + CNT_W'(1);
      end
      if (cmd.list_start && cmd.list_copy) begin
         if (cmd.list_rot) begin
            on_list_in[lst_chosen_ff] = 1'b0;
         end else if (cmd.skip_best) begin
            on_list_in[best_idx_ff] = 1'b0;
         end else begin
            on_list_in[req_idx] = 1'b0;
         end
      end
      if (app_en) begin
         on_list_in[app_val] = 1'b1;
         wait_cnt_in         = wait_cnt_ff + CNT_W'(1);
      end
      if (cmd.list_commit) begin
         wait_cnt_in = lst_k_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff  <= '0;
         unch_ff     <= '0;
         intr_ff     <= '0;
         on_list_ff  <= '0;
         taken_ff    <= '0;
         peer_cnt_ff <= '0;
         rank_ff     <= '0;
         wait_cnt_ff <= '0;
         bank_ff     <= 1'b0;
      end else begin
         present_ff  <= present_in;
         unch_ff     <= unch_in;
         intr_ff     <= intr_in;
         on_list_ff  <= on_list_in;
         taken_ff    <= taken_in;
         peer_cnt_ff <= peer_cnt_in;
         rank_ff     <= rank_in;
         wait_cnt_ff <= wait_cnt_in;
         if (cmd.list_commit) begin
            bank_ff <= !bank_ff;
         end
      end
   end

   // rate memory: one write port, one registered read port for the scan
   assign rate_we    = cmd.add_apply || cmd.rate_apply;
   assign rate_wdata = cmd.rate_apply ? req_rate_ff : '0;

   always_ff @(posedge clock) begin
      if (rate_we) begin
         rate_mem[req_idx] <= rate_wdata;
      end
      rate_rd_ff <= rate_mem[scan_addr_ff];
   end

   // scan: max over present untaken peers, or min over present unchoked
   assign scan_elig   = scan_max_ff ? (present_ff[scan_pidx_ff] && !taken_ff[scan_pidx_ff])
                                    : (present_ff[scan_pidx_ff] && unch_ff[scan_pidx_ff]);
   assign scan_better = !scan_found_ff ||
                        (scan_max_ff ? (rate_rd_ff > best_rate_ff) : (rate_rd_ff < best_rate_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_run_ff   <= 1'b0;
         scan_pv_ff    <= 1'b0;
         scan_found_ff <= 1'b0;
      end else if (cmd.scan_start) begin
         scan_run_ff   <= 1'b1;
         scan_pv_ff    <= 1'b0;
         scan_found_ff <= 1'b0;
      end else begin
         scan_pv_ff <= scan_run_ff;
         if (scan_run_ff && scan_addr_ff == LAST_IDX) begin
            scan_run_ff <= 1'b0;
         end
         if (scan_pv_ff && scan_elig && scan_better) begin
            scan_found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         scan_addr_ff <= '0;
         scan_max_ff  <= cmd.scan_max;
      end else begin
         scan_pidx_ff <= scan_addr_ff;
         if (scan_run_ff) begin
            scan_addr_ff <= scan_addr_ff + IDX_W'(1);
         end
         if (scan_pv_ff && scan_elig && scan_better) begin
            best_idx_ff  <= scan_pidx_ff;
            best_rate_ff <= rate_rd_ff;
         end
      end
   end

   // wait list sweep: read the active bank in list order from a base
   // position, either search for an interested peer or copy to the other
   // bank while dropping one entry
   assign src_sum  = {1'b0, lst_base_ff} + {1'b0, lst_j_ff};
   assign src_wrap = (src_sum >= {1'b0, wait_cnt_ff}) ? src_sum - {1'b0, wait_cnt_ff}
                                                       : src_sum;
   assign lst_addr = src_wrap[IDX_W-1:0];
   assign lst_data = bank_ff ? wl_b_rd_ff : wl_a_rd_ff;
   assign copy_wr  = lst_pv_ff && lst_copy_ff && (lst_data != lst_skip_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         lst_run_ff   <= 1'b0;
         lst_pv_ff    <= 1'b0;
         lst_found_ff <= 1'b0;
      end else if (cmd.list_start) begin
         lst_run_ff <= (wait_cnt_ff != '0);
         lst_pv_ff  <= 1'b0;
         if (!cmd.list_copy) begin
            lst_found_ff <= 1'b0;
         end
      end else begin
         lst_pv_ff <= lst_run_ff;
         if (lst_run_ff && lst_j_ff == wait_cnt_ff - CNT_W'(1)) begin
            lst_run_ff <= 1'b0;
         end
         if (lst_pv_ff && !lst_copy_ff && !lst_found_ff && intr_ff[lst_data]) begin
            lst_found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.list_start) begin
         lst_j_ff    <= '0;
         lst_k_ff    <= '0;
         lst_copy_ff <= cmd.list_copy;
         lst_base_ff <= cmd.list_rot ? lst_pos_ff + CNT_W'(1) : '0;
         if (cmd.list_rot) begin
            lst_skip_ff <= lst_chosen_ff;
         end else if (cmd.skip_best) begin
            lst_skip_ff <= best_idx_ff;
         end else begin
            lst_skip_ff <= req_idx;
         end
      end else begin
         lst_pj_ff <= lst_j_ff;
         if (lst_run_ff) begin
            lst_j_ff <= lst_j_ff + CNT_W'(1);
         end
         if (copy_wr) begin
            lst_k_ff <= lst_k_ff + CNT_W'(1);
         end
         if (lst_pv_ff && !lst_copy_ff && !lst_found_ff && intr_ff[lst_data]) begin
            lst_pos_ff    <= lst_pj_ff;
            lst_chosen_ff <= lst_data;
         end
      end
   end

   // appends go to the active bank, copies to the other one
   assign w_addr = app_en ? wait_cnt_ff[IDX_W-1:0] : lst_k_ff[IDX_W-1:0];
   assign w_data = app_en ? app_val : lst_data;
   assign wa_we  = (app_en && !bank_ff) || (copy_wr && bank_ff);
   assign wb_we  = (app_en && bank_ff) || (copy_wr && !bank_ff);

   always_ff @(posedge clock) begin
      if (wa_we) begin
         wl_a[w_addr] <= w_data;
      end
      wl_a_rd_ff <= wl_a[lst_addr];
   end

   always_ff @(posedge clock) begin
      if (wb_we) begin
         wl_b[w_addr] <= w_data;
      end
      wl_b_rd_ff <= wl_b[lst_addr];
   end

   // result staging and output register
   always_comb begin
      case (cmd.arm_tsel)
         TSEL_REQ:    arm_target = req_idx;
         TSEL_BEST:   arm_target = best_idx_ff;
         TSEL_CHOSEN: arm_target = lst_chosen_ff;
         default:     arm_target = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.arm) begin
         arm_action_ff <= cmd.arm_action;
         arm_status_ff <= cmd.arm_status;
         // unknown peer indexes echo the raw request field
         arm_target_ff <= arm_target;
      end
   end

   logic             arm_raw_ff;
   logic [PEER_ID_W-1:0] rsp_raw_ff;

   always_ff @(posedge clock) begin
      if (cmd.arm) begin
         arm_raw_ff <= (cmd.arm_tsel == TSEL_REQ);
      end
      if (cmd.fire) begin
         rsp_action_ff <= arm_action_ff;
         rsp_raw_ff    <= arm_raw_ff ? req_peer_ff : PEER_ID_W'(arm_target_ff);
         rsp_status_ff <= arm_status_ff;
         rsp_count_ff  <= peer_cnt_ff;
         rsp_last_ff   <= cmd.fire_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_action      = rsp_action_ff;
   assign rsp_target_peer = rsp_raw_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_peer_count  = COUNT_W'(rsp_count_ff);
   assign rsp_last        = rsp_last_ff;

   // status to the controller
   always_comb begin
      stat            = '0;
      stat.command    = command_type'(req_cmd_ff);
      stat.peer_valid = peer_valid;
      stat.here       = peer_valid && present_ff[req_idx];
      stat.on_req     = on_list_ff[req_idx];
      stat.on_best    = on_list_ff[best_idx_ff];
      stat.empty      = (peer_cnt_ff == '0);
      stat.scan_done  = !scan_run_ff && !scan_pv_ff;
      stat.scan_found = scan_found_ff;
      stat.list_done  = !lst_run_ff && !lst_pv_ff;
      stat.list_found = lst_found_ff;
      stat.below_max  = COUNT_W'(rank_ff) < max_unch_ff;
      stat.rank_last  = (rank_ff + CNT_W'(1)) == peer_cnt_ff;
      stat.out_free   = !rsp_valid_ff || rsp_ready;
   end

   a_cnt_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(present_ff) == peer_cnt_ff)
      else $error("peer count out of step with present flags");

   a_list_present: assert property (@(posedge clock) disable iff (reset)
      (on_list_ff & ~present_ff) == '0)
      else $error("absent peer on wait list");

   a_list_choked: assert property (@(posedge clock) disable iff (reset)
      (on_list_ff & unch_ff) == '0)
      else $error("unchoked peer on wait list");

   a_fire_free: assert property (@(posedge clock) disable iff (reset)
      cmd.fire |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwrites pending response");

endmodule
`default_nettype wire

/* hw/rtl/peer_unchoke_selector_top.sv */
// Peer unchoke selector: keeps a table of peers (present flag, unchoke
// mark, upload rate, interest) and an ordered optimistic wait list.
// Requests arrive on req_* (valid/ready); each request produces one or more
// responses on rsp_* (valid/ready), the final one flagged by rsp_last.
// csr_write_enable/csr_write_data load max_unchoked (reset value 4); write
// it only while no request is in flight.
// Requests are taken one at a time: req_ready is high only between
// requests. Remove and unchoke add one wait-list copy pass when the
// peer is on the wait list. Decide runs one scan of the rate memory per
// present peer, plus a wait-list copy pass for each unchoked peer that was
// waiting. Optimistic unchoke runs a wait-list search and, if it finds an
// interested peer, a wait-list rotation and one rate scan. Scans and passes
// go through the single read port of the rate memory and of the wait-list
// banks.
// Reset empties the table and wait list at once; no clearing pass.
// A stalled rsp_ready holds the response register and the controller waits
// before emitting the next response; nothing is dropped.
`default_nettype none
module peer_unchoke_selector_top
   import pus_pkg::*;
#(
   parameter int MAX_PEERS = DEF_PEERS,
   parameter int RATE_BITS = DEF_RATE_W
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [CMD_W-1:0]     req_command,
   input  wire logic [PEER_ID_W-1:0] req_peer_id,
   input  wire logic [RATE_IN_W-1:0] req_upload_rate,
   input  wire logic                 req_interested,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [1:0]                rsp_action,
   output logic [PEER_ID_W-1:0]      rsp_target_peer,
   output logic                      rsp_status,
   output logic [COUNT_W-1:0]        rsp_peer_count,
   output logic                      rsp_last,
   input  wire logic                 csr_write_enable,
   input  wire logic [COUNT_W-1:0]   csr_write_data
);

   pus_cmd_type  cmd;
   pus_stat_type stat;

   // sequence each request as commands to the datapath
   pus_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // tables, rate scan, wait-list banks and response register
   pus_datapath #(
      .MAX_PEERS (MAX_PEERS),
      .RATE_BITS (RATE_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_command      (req_command),
      .req_peer_id      (req_peer_id),
      .req_upload_rate  (req_upload_rate),
      .req_interested   (req_interested),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_action       (rsp_action),
      .rsp_target_peer  (rsp_target_peer),
      .rsp_status       (rsp_status),
      .rsp_peer_count   (rsp_peer_count),
      .rsp_last         (rsp_last)
   );

endmodule
`default_nettype wire
